// ----- sv/bspq_pkg.sv -----
// ----------------------------------------------------------------------------
// bspq_pkg
// shared types and constants for the button short/long press qualifier
// ----------------------------------------------------------------------------
package bspq_pkg;

  localparam int unsigned TIME_BITS_DEFAULT = 32;
  localparam int unsigned CFG_MS_BITS       = 16;
  localparam int unsigned CFG_INDEX_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS     = 16;

  localparam logic [CFG_MS_BITS-1:0] LONG_PRESS_MS_RESET = 16'd500;
  localparam logic [CFG_MS_BITS-1:0] REPEAT_GAP_MS_RESET = 16'd200;
  localparam logic                   LONG_PRESS_NAV_RESET = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LONG_PRESS_MS  = 2'd0,
    REG_REPEAT_GAP_MS  = 2'd1,
    REG_LONG_PRESS_NAV = 2'd2
  } cfg_reg_t;

  // per-key result of one poll
  typedef struct packed {
    logic long_ev;
    logic short_ev;
    logic woke;
    logic asleep_out;
  } key_ev_t;

endpackage

// ----- sv/bspq_key_track.sv -----
// ----------------------------------------------------------------------------
// bspq_key_track
// edge tracker for one OK or BACK key: short press, long press, wake swallow
// ----------------------------------------------------------------------------
module bspq_key_track #(
  parameter int unsigned TIME_BITS = bspq_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            upd,
  input  logic                            lvl,
  input  logic [TIME_BITS-1:0]            now_ms,
  input  logic                            asleep_in,
  input  logic [bspq_pkg::CFG_MS_BITS-1:0] long_press_ms,
  output bspq_pkg::key_ev_t               ev
);
  import bspq_pkg::*;

  logic                 was_pressed;
  logic                 long_fired;
  logic                 wake_swallow;
  logic [TIME_BITS-1:0] press_time;

  logic                 press_edge;
  logic                 fired_base;
  logic                 swallow_next;
  logic [TIME_BITS-1:0] press_time_next;
  logic [TIME_BITS-1:0] elapsed;
  logic                 long_ev;

  always_comb begin
    press_edge      = lvl && !was_pressed;
    press_time_next = press_edge ? now_ms : press_time;
    fired_base      = press_edge ? 1'b0 : long_fired;
    swallow_next    = press_edge ? asleep_in : wake_swallow;
    // wraps modulo 2^TIME_BITS
    elapsed         = now_ms - press_time_next;
    long_ev         = lvl && !fired_base && !swallow_next &&
                      (elapsed >= TIME_BITS'(long_press_ms));
    ev.long_ev      = long_ev;
    ev.short_ev     = !lvl && was_pressed && !fired_base && !swallow_next;
    ev.woke         = press_edge && asleep_in;
    ev.asleep_out   = asleep_in && !press_edge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed  <= 1'b0;
      long_fired   <= 1'b0;
      wake_swallow <= 1'b0;
      press_time   <= '0;
    end else if (upd) begin
      was_pressed  <= lvl;
      long_fired   <= fired_base | long_ev;
      wake_swallow <= swallow_next;
      press_time   <= press_time_next;
    end
  end

endmodule

// ----- sv/button_short_long_press_qualifier.sv -----
// ----------------------------------------------------------------------------
// button_short_long_press_qualifier
// turns polled button levels into select/escape/next/prev/up/down events
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one poll per beat: timestamp,
//   six button levels, screen-asleep and hold-repeat flags
//   output channel (out_valid / out_stall) carries one result beat per poll,
//   in order, with the event pulses and the wake flag
//   config channel (cfg_valid / cfg_ready) writes long_press_ms,
//   repeat_gap_ms and long_press_nav; cfg_ready is always high, and writes
//   are only expected while no poll is in flight
// timing:
//   a poll passes through the input register, then one pass of key tracking
//   and gap gate into the result register
//   throughput is one poll per cycle while the output does not stall; the key
//   state and gate time are updated in the same cycle a poll leaves the input
//   register, so the following poll sees them with no bubble
// reset:
//   rst clears all key tracking state and the last gate time to 0 and loads
//   the register defaults (500, 200, 1); both pipeline stages come up empty
// stall:
//   a stalled result holds in the result register; one more poll may sit in
//   the input register, after which in_stall rises until the output drains
// ----------------------------------------------------------------------------
module button_short_long_press_qualifier #(
  parameter int unsigned TIME_BITS = bspq_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // poll channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [TIME_BITS-1:0]                now_ms,
  input  logic                                btn_left,
  input  logic                                btn_up,
  input  logic                                btn_right,
  input  logic                                btn_down,
  input  logic                                btn_ok,
  input  logic                                btn_back,
  input  logic                                screen_asleep,
  input  logic                                hold_repeat,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                ev_select,
  output logic                                ev_escape,
  output logic                                ev_next,
  output logic                                ev_prev,
  output logic                                ev_up,
  output logic                                ev_down,
  output logic                                ev_any_key,
  output logic                                wake_screen,
  // config channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bspq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bspq_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import bspq_pkg::*;

  // configuration registers
  logic [CFG_MS_BITS-1:0] long_press_ms;
  logic [CFG_MS_BITS-1:0] repeat_gap_ms;
  logic                   long_press_nav;

  // input register
  logic                 s1_valid;
  logic [TIME_BITS-1:0] s1_now;
  logic                 s1_left, s1_up, s1_right, s1_down, s1_ok, s1_back;
  logic                 s1_asleep, s1_hold;

  // gate state
  logic [TIME_BITS-1:0] last_gate_time;

  // pass logic
  logic                 s2_fire;
  logic                 in_fire;
  logic                 key_upd;
  key_ev_t              ok_ev, back_ev;
  logic                 any_btn;
  logic                 admit;
  logic                 asleep_mid;
  logic                 gate_wake;
  logic                 gated;
  logic [TIME_BITS-1:0] gap;
  logic                 sel, esc, nxt, prv, eup, edn, any, woke;

  assign cfg_ready = 1'b1;

  // stage 2 moves when the result register is empty or being drained
  assign s2_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s2_fire;
  assign in_fire  = in_valid && !in_stall;
  assign key_upd  = s2_fire && long_press_nav;

  bspq_key_track #(.TIME_BITS(TIME_BITS)) u_ok (
    .clk           (clk),
    .rst           (rst),
    .upd           (key_upd),
    .lvl           (s1_ok),
    .now_ms        (s1_now),
    .asleep_in     (s1_asleep),
    .long_press_ms (long_press_ms),
    .ev            (ok_ev)
  );

  // back sees the screen as ok left it
  bspq_key_track #(.TIME_BITS(TIME_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .upd           (key_upd),
    .lvl           (s1_back),
    .now_ms        (s1_now),
    .asleep_in     (ok_ev.asleep_out),
    .long_press_ms (long_press_ms),
    .ev            (back_ev)
  );

  always_comb begin
    any_btn    = s1_left || s1_up || s1_right || s1_down || s1_ok || s1_back;
    // with nav off the key trackers are bypassed entirely
    asleep_mid = long_press_nav ? back_ev.asleep_out : s1_asleep;
    gap        = s1_now - last_gate_time;
    admit      = (gap > TIME_BITS'(repeat_gap_ms)) || s1_hold;
    // a pressed poll through the gate while still asleep only wakes
    gate_wake  = admit && any_btn && asleep_mid;
    gated      = admit && !gate_wake;

    sel  = (long_press_nav && ok_ev.short_ev) ||
           (gated && !long_press_nav && s1_ok);
    esc  = (long_press_nav && back_ev.short_ev) ||
           (gated && !long_press_nav && s1_back);
    nxt  = (long_press_nav && ok_ev.long_ev) || (gated && s1_right);
    prv  = (long_press_nav && back_ev.long_ev) || (gated && s1_left);
    eup  = gated && s1_up;
    edn  = gated && s1_down;
    any  = (long_press_nav && (ok_ev.short_ev || ok_ev.long_ev ||
                               back_ev.short_ev || back_ev.long_ev)) ||
           (gated && any_btn);
    woke = (long_press_nav && (ok_ev.woke || back_ev.woke)) || gate_wake;
  end

  // config, pipeline control and gate time
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms  <= LONG_PRESS_MS_RESET;
      repeat_gap_ms  <= REPEAT_GAP_MS_RESET;
      long_press_nav <= LONG_PRESS_NAV_RESET;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      last_gate_time <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LONG_PRESS_MS:  long_press_ms  <= cfg_data;
          REG_REPEAT_GAP_MS:  repeat_gap_ms  <= cfg_data;
          REG_LONG_PRESS_NAV: long_press_nav <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s2_fire) begin
        s1_valid <= 1'b0;
      end
      if (s2_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (s2_fire && admit && any_btn) begin
        last_gate_time <= s1_now;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now    <= now_ms;
      s1_left   <= btn_left;
      s1_up     <= btn_up;
      s1_right  <= btn_right;
      s1_down   <= btn_down;
      s1_ok     <= btn_ok;
      s1_back   <= btn_back;
      s1_asleep <= screen_asleep;
      s1_hold   <= hold_repeat;
    end
    if (s2_fire) begin
      ev_select   <= sel;
      ev_escape   <= esc;
      ev_next     <= nxt;
      ev_prev     <= prv;
      ev_up       <= eup;
      ev_down     <= edn;
      ev_any_key  <= any;
      wake_screen <= woke;
    end
  end

  // input side only backs up when a poll is waiting in the input register
  a_stall_needs_poll: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall with empty input register");

  // a gated pressed poll moves the gate time to its timestamp
  a_gate_time: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && admit && any_btn) |=> (last_gate_time == $past(s1_now)))
    else $error("gate time not updated");

  // up/down only pass the gate awake, which always flags any-key
  a_dir_any: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (ev_up || ev_down)) |-> ev_any_key)
    else $error("directional event without any-key");

  // a result leaves the register only when taken
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the button short/long press qualifier one poll at a time against an
// event predictor kept in the bench, over several register settings, with
// random idle gaps on the poll side and random stalls on the result side
// ----------------------------------------------------------------------------
module tb;
  import bspq_pkg::*;

  localparam int unsigned TB_BITS = TIME_BITS_DEFAULT;

  // bit positions of the six buttons inside a key vector
  localparam int KEY_LEFT  = 5;
  localparam int KEY_UP    = 4;
  localparam int KEY_RIGHT = 3;
  localparam int KEY_DOWN  = 2;
  localparam int KEY_OK    = 1;
  localparam int KEY_BACK  = 0;

  localparam int NUM_ROWS        = 25;
  localparam int PHASES          = 8;
  localparam int POLLS_PER_PHASE = 190;
  localparam int MAX_WAIT        = 16;
  localparam int DRAIN_CYCLES    = 10;
  localparam longint TIMEOUT_NS  = 64'd10_000_000;

  // one poll as the bench sees it
  typedef struct packed {
    logic [TB_BITS-1:0] now_stamp;
    logic [5:0]         keys;
    logic               asleep;
    logic               hold;
  } poll_t;

  // one result beat, msb first in port order
  typedef struct packed {
    logic sel;
    logic esc;
    logic nxt;
    logic prv;
    logic up;
    logic dn;
    logic any_key;
    logic wake;
  } res_t;

  // a row of the directed script; want is used only where typed is set
  typedef struct packed {
    logic [TB_BITS-1:0] now_stamp;
    logic [5:0]         keys;
    logic               asleep;
    logic               hold;
    logic               typed;
    res_t               want;
  } script_row_t;

  // OK or BACK tracking state
  typedef struct packed {
    logic               held;
    logic [TB_BITS-1:0] since;
    logic               long_done;
    logic               swallowed;
  } key_track_t;

  // ports; the ones the bench drives are all known from time zero
  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [TB_BITS-1:0] now_ms        = '0;
  logic               btn_left      = 1'b0;
  logic               btn_up        = 1'b0;
  logic               btn_right     = 1'b0;
  logic               btn_down      = 1'b0;
  logic               btn_ok        = 1'b0;
  logic               btn_back      = 1'b0;
  logic               screen_asleep = 1'b0;
  logic               hold_repeat   = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               ev_select;
  logic               ev_escape;
  logic               ev_next;
  logic               ev_prev;
  logic               ev_up;
  logic               ev_down;
  logic               ev_any_key;
  logic               wake_screen;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  button_short_long_press_qualifier #(
    .TIME_BITS(TB_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_ms       (now_ms),
    .btn_left     (btn_left),
    .btn_up       (btn_up),
    .btn_right    (btn_right),
    .btn_down     (btn_down),
    .btn_ok       (btn_ok),
    .btn_back     (btn_back),
    .screen_asleep(screen_asleep),
    .hold_repeat  (hold_repeat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ev_select    (ev_select),
    .ev_escape    (ev_escape),
    .ev_next      (ev_next),
    .ev_prev      (ev_prev),
    .ev_up        (ev_up),
    .ev_down      (ev_down),
    .ev_any_key   (ev_any_key),
    .wake_screen  (wake_screen),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 50 MHz
  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // event predictor: its own copy of the key tracking, gate time and settings
  // --------------------------------------------------------------------------
  logic [CFG_MS_BITS-1:0] hold_ms_setting = LONG_PRESS_MS_RESET;
  logic [CFG_MS_BITS-1:0] gap_ms_setting  = REPEAT_GAP_MS_RESET;
  logic                   nav_setting     = LONG_PRESS_NAV_RESET;
  key_track_t             ok_track        = '0;
  key_track_t             back_track      = '0;
  logic [TB_BITS-1:0]     gate_stamp      = '0;

  // expected result beats, oldest first
  res_t pending_events [$];

  int polls_sent      = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int settings_used   = 1;
  int event_seen [8];

  string field_name [0:7] = '{"ev_select", "ev_escape", "ev_next", "ev_prev",
                              "ev_up", "ev_down", "ev_any_key", "wake_screen"};

  // edge tracking of one of OK or BACK; the screen wakes on a press edge
  // while asleep, and that whole hold is swallowed
  function automatic void step_key(input logic lvl, input logic [TB_BITS-1:0] stamp,
                                   inout logic asleep, inout logic woke,
                                   inout key_track_t k, inout logic long_ev,
                                   inout logic short_ev);
    logic [TB_BITS-1:0] held_for;
    if (lvl && !k.held) begin
      k.since     = stamp;
      k.long_done = 1'b0;
      k.swallowed = asleep;
      if (asleep) begin
        woke   = 1'b1;
        asleep = 1'b0;
      end
    end
    held_for = stamp - k.since;
    if (lvl && !k.long_done && !k.swallowed && held_for >= hold_ms_setting) begin
      long_ev     = 1'b1;
      k.long_done = 1'b1;
    end
    if (!lvl && k.held && !k.long_done && !k.swallowed)
      short_ev = 1'b1;
    k.held = lvl;
  endfunction

  function automatic res_t predict_events(input poll_t p);
    res_t               r;
    logic               asleep;
    logic               gated;
    logic [TB_BITS-1:0] since_gate;
    r      = '0;
    asleep = p.asleep;
    if (nav_setting) begin
      step_key(p.keys[KEY_OK], p.now_stamp, asleep, r.wake, ok_track, r.nxt, r.sel);
      step_key(p.keys[KEY_BACK], p.now_stamp, asleep, r.wake, back_track, r.prv, r.esc);
      if (r.nxt || r.sel || r.prv || r.esc)
        r.any_key = 1'b1;
    end
    since_gate = p.now_stamp - gate_stamp;
    if (since_gate > gap_ms_setting || p.hold) begin
      gated = 1'b1;
      if (p.keys != '0) begin
        gate_stamp = p.now_stamp;
        if (asleep) begin
          r.wake = 1'b1;
          gated  = 1'b0;
        end else begin
          r.any_key = 1'b1;
        end
      end
      if (gated) begin
        if (p.keys[KEY_LEFT])  r.prv = 1'b1;
        if (p.keys[KEY_RIGHT]) r.nxt = 1'b1;
        if (p.keys[KEY_UP])    r.up  = 1'b1;
        if (p.keys[KEY_DOWN])  r.dn  = 1'b1;
        if (!nav_setting) begin
          if (p.keys[KEY_OK])   r.sel = 1'b1;
          if (p.keys[KEY_BACK]) r.esc = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, each accepted beat checked against the oldest
  // expectation
  // --------------------------------------------------------------------------
  int   stall_left = 0;
  logic recv_burst = 1'b0;

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    int   k;
    if (!rst && out_valid && !out_stall) begin
      got = {ev_select, ev_escape, ev_next, ev_prev, ev_up, ev_down, ev_any_key,
             wake_screen};
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("result beat %b with nothing expected", got));
      end else begin
        want = pending_events.pop_front();
        for (k = 7; k >= 0; k--) begin
          if (got[k] !== want[k])
            flag_mismatch($sformatf("beat %0d %s got %b want %b", results_checked,
                                    field_name[7-k], got[k], want[k]));
          if (want[k])
            event_seen[7-k]++;
        end
        results_checked++;
      end
      // draw the stall that follows this beat; burst stretches take none
      if ($urandom_range(0, 39) == 0)
        recv_burst = !recv_burst;
      stall_left = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // poll side
  // --------------------------------------------------------------------------
  logic send_burst = 1'b0;

  // one poll beat after a random idle gap; the prediction is taken at the
  // accepting edge, a typed row overrides it but the state still moves
  task automatic drive_poll(input poll_t p, input logic typed, input res_t typed_want);
    int   gap;
    res_t want;
    if ($urandom_range(0, 39) == 0)
      send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    now_ms        <= p.now_stamp;
    btn_left      <= p.keys[KEY_LEFT];
    btn_up        <= p.keys[KEY_UP];
    btn_right     <= p.keys[KEY_RIGHT];
    btn_down      <= p.keys[KEY_DOWN];
    btn_ok        <= p.keys[KEY_OK];
    btn_back      <= p.keys[KEY_BACK];
    screen_asleep <= p.asleep;
    hold_repeat   <= p.hold;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_events(p);
    if (typed)
      want = typed_want;
    pending_events.push_back(want);
    polls_sent++;
  endtask

  // all three registers in back-to-back beats; only called with nothing in flight
  task automatic load_settings(input logic [CFG_MS_BITS-1:0] hold_ms,
                               input logic [CFG_MS_BITS-1:0] gap_ms,
                               input logic nav);
    int i;
    for (i = 0; i < 3; i++) begin
      case (i)
        0: begin
          cfg_index <= REG_LONG_PRESS_MS;
          cfg_data  <= hold_ms;
        end
        1: begin
          cfg_index <= REG_REPEAT_GAP_MS;
          cfg_data  <= gap_ms;
        end
        default: begin
          cfg_index <= REG_LONG_PRESS_NAV;
          cfg_data  <= {{(CFG_DATA_BITS-1){1'b0}}, nav};
        end
      endcase
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid       <= 1'b0;
    hold_ms_setting  = hold_ms;
    gap_ms_setting   = gap_ms;
    nav_setting      = nav;
    settings_used++;
  endtask

  initial begin : stimulus
    script_row_t            script [NUM_ROWS];
    poll_t                  poll;
    logic [TB_BITS-1:0]     clock_ms;
    logic [5:0]             held;
    logic [CFG_MS_BITS-1:0] hold_ms;
    logic [CFG_MS_BITS-1:0] gap_ms;
    logic                   nav;
    int unsigned            span;
    int unsigned            pick;
    int                     n;
    int                     b;
    int                     phase;

    // directed script at reset settings (hold 500, gap 200, nav on)
    // keys are {left, up, right, down, ok, back}
    // want is {select, escape, next, prev, up, down, any, wake}
    // idle poll right after reset: gate closed since no time has passed
    script[0]  = '{32'd0,          6'b000000, 1'b0, 1'b0, 1'b1, 8'b0000_0000};
    // timestamp at its top with left: gate open, prev and any-key
    script[1]  = '{32'hFFFF_FFFF,  6'b100000, 1'b0, 1'b0, 1'b1, 8'b0001_0010};
    // time wraps to a small gap, gate stays closed; then hold-repeat opens it
    script[2]  = '{32'd100,        6'b001000, 1'b0, 1'b0, 1'b0, 8'b0};
    script[3]  = '{32'd100,        6'b001000, 1'b0, 1'b1, 1'b0, 8'b0};
    // short OK press, with a poll at exactly the gate gap
    script[4]  = '{32'd1000,       6'b000010, 1'b0, 1'b0, 1'b0, 8'b0};
    script[5]  = '{32'd1200,       6'b000010, 1'b0, 1'b0, 1'b0, 8'b0};
    script[6]  = '{32'd1300,       6'b000000, 1'b0, 1'b0, 1'b0, 8'b0};
    // long OK press hitting the threshold exactly, fires once per hold
    script[7]  = '{32'd2000,       6'b000010, 1'b0, 1'b0, 1'b0, 8'b0};
    script[8]  = '{32'd2500,       6'b000010, 1'b0, 1'b0, 1'b0, 8'b0};
    script[9]  = '{32'd3000,       6'b000010, 1'b0, 1'b0, 1'b0, 8'b0};
    script[10] = '{32'd3100,       6'b000000, 1'b0, 1'b0, 1'b0, 8'b0};
    // short BACK, then a BACK hold just under and at the threshold
    script[11] = '{32'd4000,       6'b000001, 1'b0, 1'b0, 1'b0, 8'b0};
    script[12] = '{32'd4100,       6'b000000, 1'b0, 1'b0, 1'b0, 8'b0};
    script[13] = '{32'd5000,       6'b000001, 1'b0, 1'b0, 1'b0, 8'b0};
    script[14] = '{32'd5499,       6'b000001, 1'b0, 1'b0, 1'b0, 8'b0};
    script[15] = '{32'd5500,       6'b000001, 1'b0, 1'b0, 1'b0, 8'b0};
    script[16] = '{32'd6000,       6'b000000, 1'b0, 1'b0, 1'b0, 8'b0};
    // OK press that wakes the screen is swallowed for the whole hold
    script[17] = '{32'd7000,       6'b000010, 1'b1, 1'b0, 1'b0, 8'b0};
    script[18] = '{32'd8000,       6'b000010, 1'b0, 1'b0, 1'b0, 8'b0};
    script[19] = '{32'd8100,       6'b000000, 1'b0, 1'b0, 1'b0, 8'b0};
    // gate opens on a sleeping screen: wake only, then up and down
    script[20] = '{32'd9000,       6'b010000, 1'b1, 1'b0, 1'b0, 8'b0};
    script[21] = '{32'd9500,       6'b010100, 1'b0, 1'b0, 1'b0, 8'b0};
    // OK wakes first so BACK in the same poll sees an awake screen
    script[22] = '{32'd10000,      6'b000011, 1'b1, 1'b0, 1'b0, 8'b0};
    // release both under hold-repeat with no button down: gate time kept
    script[23] = '{32'd10001,      6'b000000, 1'b0, 1'b1, 1'b0, 8'b0};
    // every button at once while asleep, with hold-repeat
    script[24] = '{32'd10002,      6'b111111, 1'b1, 1'b1, 1'b0, 8'b0};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < NUM_ROWS; n++) begin
      poll.now_stamp = script[n].now_stamp;
      poll.keys      = script[n].keys;
      poll.asleep    = script[n].asleep;
      poll.hold      = script[n].hold;
      drive_poll(poll, script[n].typed, script[n].want);
    end
    in_valid <= 1'b0;

    clock_ms = 32'd20000;
    held     = '0;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin hold_ms = 16'd1;     gap_ms = 16'd0;     nav = 1'b1; end
        1: begin hold_ms = 16'hFFFF;  gap_ms = 16'hFFFF;  nav = 1'b1; end
        // zero hold time: every OK or BACK press that is not swallowed is long on its edge poll
        2: begin hold_ms = 16'd0;     gap_ms = 16'd200;   nav = 1'b1; end
        3: begin hold_ms = 16'd20;    gap_ms = 16'd10;    nav = 1'b0; end
        4: begin hold_ms = 16'hFFFF;  gap_ms = 16'd0;     nav = 1'b0; end
        default: begin
          hold_ms = CFG_MS_BITS'($urandom_range(0, 1500));
          gap_ms  = CFG_MS_BITS'($urandom_range(0, 800));
          nav     = 1'($urandom_range(0, 1));
        end
      endcase

      // registers only move with nothing in flight
      while (pending_events.size() != 0) @(posedge clk);
      load_settings(hold_ms, gap_ms, nav);

      // step sizes scale with the settings so holds and gaps land on both sides
      span = ((hold_ms > gap_ms) ? hold_ms : gap_ms) + 1;
      for (n = 0; n < POLLS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5)
          clock_ms = $urandom;
        else if (pick < 75)
          clock_ms = clock_ms + $urandom_range(0, span / 3 + 1);
        else if (pick < 95)
          clock_ms = clock_ms + $urandom_range(span / 3, 2 * span + 2);
        else
          clock_ms = 32'hFFFF_FFFF - $urandom_range(0, span);

        // buttons mostly held across polls, now and then all scrambled
        if ($urandom_range(0, 9) == 0) begin
          held = 6'($urandom);
        end else begin
          for (b = 0; b < 6; b++)
            if ($urandom_range(0, 4) == 0)
              held[b] = ~held[b];
        end

        poll.now_stamp = clock_ms;
        poll.keys      = held;
        poll.asleep    = ($urandom_range(0, 5) == 0);
        poll.hold      = ($urandom_range(0, 4) == 0);
        drive_poll(poll, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    while (pending_events.size() != 0) @(posedge clk);
    // wait DRAIN_CYCLES more so a stray extra beat is caught
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d polls over %0d register settings, %0d result beats checked",
             polls_sent, settings_used, results_checked);
    $display("events: select %0d escape %0d next %0d prev %0d up %0d down %0d any %0d wake %0d",
             event_seen[0], event_seen[1], event_seen[2], event_seen[3],
             event_seen[4], event_seen[5], event_seen[6], event_seen[7]);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d result beats outstanding", pending_events.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bspq_pkg.sv
sv/bspq_key_track.sv
sv/button_short_long_press_qualifier.sv
bench/tb.sv
